[rtl/core/dqvr_pkg.sv]
// ----------------------------------------------------------------------------
// dqvr_pkg
// Shared types and constants for the deque with removal by value.
// ----------------------------------------------------------------------------
package dqvr_pkg;

    localparam int DEPTH   = 16;
    localparam int ENTRY_W = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_REM_VALUE = 3'd2,
        ACT_REM_FRONT = 3'd3,
        ACT_REM_BACK  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                      en;
        logic [2:0]                act;
        logic signed [ENTRY_W-1:0] val;
        logic [CNT_W-1:0]          count;
        logic                      full;
        logic                      empty;
    } t_cell_ctl;

endpackage

[rtl/core/dqvr_cell.sv]
// ----------------------------------------------------------------------------
// dqvr_cell
// One position of the deque: holds an entry, matches it, shifts with neighbors.
// ----------------------------------------------------------------------------
module dqvr_cell
    import dqvr_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic [IDX_W-1:0]          i_idx,
    input  logic signed [ENTRY_W-1:0] i_left,
    input  logic signed [ENTRY_W-1:0] i_right,
    input  logic                      i_found,
    input  logic signed [ENTRY_W-1:0] i_tail,
    output logic                      o_found,
    output logic signed [ENTRY_W-1:0] o_tail,
    output logic signed [ENTRY_W-1:0] o_entry
);

    logic signed [ENTRY_W-1:0] r_entry;
    logic signed [ENTRY_W-1:0] n_entry;
    logic [CNT_W-1:0]          w_pos;
    logic                      w_used;
    logic                      w_last;
    logic                      w_match;

    assign w_pos   = CNT_W'(i_idx);
    assign w_used  = w_pos < i_ctl.count;
    assign w_last  = (w_pos + CNT_W'(1)) == i_ctl.count;
    assign w_match = w_used && (r_entry == i_ctl.val);
    assign o_found = i_found | w_match;
    assign o_tail  = w_last ? r_entry : i_tail;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.act)
            ACT_INS_FRONT: begin
                if (!i_ctl.full) n_entry = i_left;
            end
            ACT_INS_BACK: begin
                if (!i_ctl.full && (w_pos == i_ctl.count)) n_entry = i_ctl.val;
            end
            ACT_REM_VALUE: begin
                // close the gap at and after the first match
                if (o_found) n_entry = i_right;
            end
            ACT_REM_FRONT: begin
                if (!i_ctl.empty) n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) r_entry <= n_entry;
    end

endmodule

[rtl/core/deque_with_value_removal_core.sv]
// ----------------------------------------------------------------------------
// deque_with_value_removal_core
// Deque of signed entries with insert/remove at both ends and removal by value.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// input   | in        | i_valid / o_stall  | i_action, i_item_value
// output  | out       | o_valid / i_stall  | o_status, o_entry_count,
//         |           |                    | o_head_value, o_tail_value
//
// On acceptance of a transaction the cell row updates, and the result is then
// read from the updated row into the output register (tail through the cell
// chain). No new transaction is accepted while a result is still pending.
// Reset clears the count and handshake state; cell contents are left as is.
// A result stalled downstream holds the row and stalls the input side.
// ----------------------------------------------------------------------------
module deque_with_value_removal_core
    import dqvr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_action,
    input  logic signed [31:0] i_item_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [4:0]         o_entry_count,
    output logic signed [31:0] o_head_value,
    output logic signed [31:0] o_tail_value
);

    t_cell_ctl                 w_ctl;
    logic signed [ENTRY_W-1:0] w_entry [DEPTH];
    logic                      w_found [DEPTH+1];
    logic signed [ENTRY_W-1:0] w_tail  [DEPTH+1];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_pend;
    t_status          r_status;
    t_status          n_status;
    logic             w_in_acc;
    logic             w_load;

    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [4:0]       r_out_count;
    logic signed [31:0] r_out_head;
    logic signed [31:0] r_out_tail;

    // Accept only with no result waiting to be formed, and room at the output.
    assign o_stall  = r_pend || (r_out_valid && i_stall);
    assign w_in_acc = i_valid && !o_stall;
    assign w_load   = r_pend && (!r_out_valid || !i_stall);

    assign w_ctl.en    = w_in_acc;
    assign w_ctl.act   = i_action;
    assign w_ctl.val   = i_item_value;
    assign w_ctl.count = r_count;
    assign w_ctl.full  = r_count == CNT_W'(DEPTH);
    assign w_ctl.empty = r_count == '0;

    assign w_found[0] = 1'b0;
    assign w_tail[0]  = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [ENTRY_W-1:0] w_left;
        logic signed [ENTRY_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_item_value;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        dqvr_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_idx   (IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .i_found (w_found[g]),
            .i_tail  (w_tail[g]),
            .o_found (w_found[g+1]),
            .o_tail  (w_tail[g+1]),
            .o_entry (w_entry[g])
        );
    end

    // Next count and status of the accepted transaction.
    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        case (i_action)
            ACT_INS_FRONT, ACT_INS_BACK: begin
                if (w_ctl.full) n_status = ST_FULL;
                else            n_count  = r_count + CNT_W'(1);
            end
            ACT_REM_VALUE: begin
                if (w_ctl.empty)         n_status = ST_EMPTY;
                else if (!w_found[DEPTH]) n_status = ST_NOTFOUND;
                else                     n_count  = r_count - CNT_W'(1);
            end
            ACT_REM_FRONT, ACT_REM_BACK: begin
                if (w_ctl.empty) n_status = ST_EMPTY;
                else             n_count  = r_count - CNT_W'(1);
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count <= n_count;
                r_pend  <= 1'b1;
            end else if (w_load) begin
                r_pend  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_status <= n_status;
    end

    // Output register: advance when empty or being taken, else hold.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_status;
            r_out_count  <= 5'(r_count);
            r_out_head   <= (r_count == '0) ? '0 : w_entry[0];
            r_out_tail   <= w_tail[DEPTH];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;
    assign o_head_value  = r_out_head;
    assign o_tail_value  = r_out_tail;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_accept_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_pend)
        else $error("accepted transaction not pending");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_status == ST_FULL) |-> (r_count == CNT_W'(DEPTH)))
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_status == ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with entries stored");

endmodule
